// ===== sv/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants of the lifo stack with peek
// command, status and state codes, default sizes and width helpers
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int WORD_BITS_DEFAULT = 32;

   // fixed field widths of the channels
   localparam int CMD_W  = 2;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 7;
   localparam int CAP_W  = 7;
   localparam int STAT_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_PEEK = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2,
      STAT_BADPOS    = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   // address bits of a memory of the given depth
   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // bits of a counter that holds 0..depth
   function automatic int cnt_bits(input int depth);
      return $clog2(depth + 1);
   endfunction

endpackage

// ===== sv/lsp_channels.sv =====
// ----------------------------------------------------------------------------
// lsp_channels: valid/ready channels of the lifo stack with peek
// request, response and control register write channels
// ----------------------------------------------------------------------------
interface lsp_req_if
   import lsp_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [VAL_W-1:0]  value;
   logic [POS_W-1:0]         position;

   modport source (output valid, output command, output value, output position,
                   input ready);
   modport sink   (input valid, input command, input value, input position,
                   output ready);
endinterface

interface lsp_rsp_if
   import lsp_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  data;
   logic [STAT_W-1:0]        status;
   logic                     full_res;
   logic                     empty_res;

   modport source (output valid, output data, output status, output full_res,
                   output empty_res, input ready);
   modport sink   (input valid, input data, input status, input full_res,
                   input empty_res, output ready);
endinterface

interface lsp_csr_if
   import lsp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CAP_W-1:0]  capacity;

   modport source (output valid, output capacity, input ready);
   modport sink   (input valid, input capacity, output ready);
endinterface

// ===== sv/lsp_ram.sv =====
// ----------------------------------------------------------------------------
// lsp_ram: stack entry storage
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module lsp_ram
   import lsp_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [addr_bits(DEPTH)-1:0]   wr_addr,
   input  logic [WORD_BITS-1:0]          wr_data,
   input  logic                          rd_en,
   input  logic [addr_bits(DEPTH)-1:0]   rd_addr,
   output logic [WORD_BITS-1:0]          rd_data_ff
);

   logic [WORD_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/lsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsp_ctrl: stack pointer, capacity register and response register
// decodes each request beat, drives the memory and builds the response
// ----------------------------------------------------------------------------
module lsp_ctrl
   import lsp_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   lsp_req_if.sink                       req_chan,
   lsp_rsp_if.source                     rsp_chan,
   lsp_csr_if.sink                       csr_chan,
   output logic                          mem_wr_en,
   output logic [addr_bits(DEPTH)-1:0]   mem_wr_addr,
   output logic [WORD_BITS-1:0]          mem_wr_data,
   output logic                          mem_rd_en,
   output logic [addr_bits(DEPTH)-1:0]   mem_rd_addr,
   input  logic [WORD_BITS-1:0]          mem_rd_data
);

   localparam int ADDR_W = addr_bits(DEPTH);
   localparam int CNT_W  = cnt_bits(DEPTH);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CAP_W-1:0]       cap_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       rsp_data_ff, rsp_data_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_full_ff, rsp_full_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   // flags of a pop or peek held while the memory read is in flight
   logic                   pend_full_ff, pend_empty_ff;

   logic                   accept;
   logic                   need_read;
   logic                   do_write;
   status_type             dec_status;
   logic [VAL_W-1:0]       dec_data;
   logic [CNT_W-1:0]       dec_count;
   logic [CMP_W-1:0]       eff_cap, cnt_ext, pos_ext, new_cnt_ext;
   logic [CMP_W-1:0]       rd_index;
   logic [WORD_BITS-1:0]   push_word;
   logic                   new_full, new_empty;
   logic [2*VAL_W-1:0]     value_ext;

   // capacity saturates at the memory depth
   always_comb begin
      eff_cap = (CMP_W'(cap_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_ff);
   end

   assign cnt_ext   = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(req_chan.position);
   assign value_ext = {{VAL_W{req_chan.value[VAL_W-1]}}, req_chan.value};
   assign push_word = WORD_BITS'(value_ext);

   // request decode
   always_comb begin
      dec_status = STAT_OK;
      dec_data   = '0;
      dec_count  = count_ff;
      need_read  = 1'b0;
      do_write   = 1'b0;
      rd_index   = '0;
      case (cmd_type'(req_chan.command))
         CMD_PUSH: begin
            if (cnt_ext >= eff_cap) begin
               dec_status = STAT_OVERFLOW;
            end else begin
               do_write  = 1'b1;
               dec_data  = VAL_W'(push_word);
               dec_count = count_ff + CNT_W'(1);
            end
         end
         CMD_POP: begin
            if (count_ff == '0) begin
               dec_status = STAT_UNDERFLOW;
            end else begin
               need_read = 1'b1;
               rd_index  = cnt_ext - CMP_W'(1);
               dec_count = count_ff - CNT_W'(1);
            end
         end
         CMD_PEEK: begin
            if (count_ff == '0) begin
               dec_status = STAT_UNDERFLOW;
            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
               dec_status = STAT_BADPOS;
            end else begin
               need_read = 1'b1;
               rd_index  = cnt_ext - pos_ext;
            end
         end
         default: begin
         end
      endcase
   end

   assign new_cnt_ext = CMP_W'(dec_count);
   assign new_full    = (new_cnt_ext >= eff_cap);
   assign new_empty   = (dec_count == '0);

   // handshakes
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // memory ports
   assign mem_wr_en   = accept && do_write;
   assign mem_wr_addr = ADDR_W'(count_ff);
   assign mem_wr_data = push_word;
   assign mem_rd_en   = accept && need_read;
   assign mem_rd_addr = ADDR_W'(rd_index);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && need_read) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_empty_in  = rsp_empty_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_in = dec_count;
               if (!need_read) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = dec_data;
                  rsp_status_in = dec_status;
                  rsp_full_in   = new_full;
                  rsp_empty_in  = new_empty;
               end
            end
         end
         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = VAL_W'(mem_rd_data);
            rsp_status_in = STAT_OK;
            rsp_full_in   = pend_full_ff;
            rsp_empty_in  = pend_empty_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            cap_ff <= csr_chan.capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_empty_ff  <= rsp_empty_in;
      if (accept) begin
         pend_full_ff  <= new_full;
         pend_empty_ff <= new_empty;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.data      = rsp_data_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.full_res  = rsp_full_ff;
   assign rsp_chan.empty_res = rsp_empty_ff;

endmodule

// ===== sv/lifo_stack_with_peek.sv =====
// push, no-op and any error beat answer in the cycle after accept
// pop and peek answer through the memory read register, then the response register
// throughput: 1 beat per cycle for push/error while the response is not stalled
// pop/peek: no new beat is taken until the memory read (S_READ) is done
// reset: synchronous, clears the stack count and sets capacity to 64
// entries are not cleared; no clearing pass after reset
// ----------------------------------------------------------------------------
// lifo_stack_with_peek: bounded stack of signed words with push, pop, peek
// entries live in one synchronous memory; control keeps the pointer
// ----------------------------------------------------------------------------
module lifo_stack_with_peek
   import lsp_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lsp_req_if.sink    req_chan,   // request beats: command, value, position
   lsp_rsp_if.source  rsp_chan,   // response beats: data, status, flags
   lsp_csr_if.sink    csr_chan    // capacity register writes
);

   localparam int ADDR_W = addr_bits(DEPTH);

   // memory port wiring between control and storage
   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [WORD_BITS-1:0]  mem_wr_data;
   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [WORD_BITS-1:0]  mem_rd_data;

   // pointer, decode, capacity register and response register
   lsp_ctrl #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_chan    (csr_chan),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // entry storage: a push writes at the count, a pop or peek reads below it
   // reads only follow the write of an earlier beat, so no forwarding path
   lsp_ram #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ram (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

endmodule

// ===== dv/lifo_stack_with_peek_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lifo_stack_with_peek_test: self-checking bench of the lifo stack with peek
// mirrors the stack in a shadow model, drives push/pop/peek beats with
// random gaps and back-pressure, and compares every response beat in order
// ----------------------------------------------------------------------------
module lifo_stack_with_peek_test;
   import lsp_pkg::*;

   // one expected response beat
   typedef struct {
      logic signed [VAL_W-1:0] data;
      status_type              status;
      logic                    full;
      logic                    empty;
   } stack_reply_type;

   // shadow copy of the stack: predicts the response of each accepted request
   class stack_mirror;
      logic signed [VAL_W-1:0] words [DEPTH_DEFAULT];
      int unsigned             held;
      int unsigned             cap_limit;
      stack_reply_type         pending_replies [$];
      int                      errors;
      int                      beats_seen;

      function new();
         held       = 0;
         errors     = 0;
         beats_seen = 0;
         set_capacity(CAP_RESET);
      endfunction

      // capacity above the storage depth saturates at the depth
      function void set_capacity(logic [CAP_W-1:0] cap);
         cap_limit = (cap > DEPTH_DEFAULT) ? DEPTH_DEFAULT : cap;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function void note_request(cmd_type cmd, logic signed [VAL_W-1:0] value,
                                 logic [POS_W-1:0] pos);
         stack_reply_type r;
         r.data   = '0;
         r.status = STAT_OK;
         case (cmd)
            CMD_PUSH: begin
               if (held >= cap_limit) begin
                  r.status = STAT_OVERFLOW;
               end else begin
                  words[held] = value;
                  r.data      = value;
                  held++;
               end
            end
            CMD_POP: begin
               if (held == 0) begin
                  r.status = STAT_UNDERFLOW;
               end else begin
                  held--;
                  r.data = words[held];
               end
            end
            CMD_PEEK: begin
               // empty wins over a bad position
               if (held == 0) begin
                  r.status = STAT_UNDERFLOW;
               end else if (pos == 0 || pos > held) begin
                  r.status = STAT_BADPOS;
               end else begin
                  r.data = words[held - pos];
               end
            end
            default: ;
         endcase
         r.full  = (held >= cap_limit);
         r.empty = (held == 0);
         pending_replies.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $time, msg);
      endtask

      task check_reply(logic signed [VAL_W-1:0] data, logic [STAT_W-1:0] status,
                       logic full, logic empty);
         stack_reply_type want;
         beats_seen++;
         if (pending_replies.size() == 0) begin
            report($sformatf("response beat %0d with nothing expected", beats_seen));
            return;
         end
         want = pending_replies.pop_front();
         if (data !== want.data)
            report($sformatf("beat %0d data %h, expected %h", beats_seen, data, want.data));
         if (status !== want.status)
            report($sformatf("beat %0d status %0d, expected %0d", beats_seen, status,
                             want.status));
         if (full !== want.full)
            report($sformatf("beat %0d full %b, expected %b", beats_seen, full, want.full));
         if (empty !== want.empty)
            report($sformatf("beat %0d empty %b, expected %b", beats_seen, empty,
                             want.empty));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   lsp_req_if req_bus ();
   lsp_rsp_if rsp_bus ();
   lsp_csr_if csr_bus ();

   stack_mirror mirror = new();

   // idle modes: off gives back-to-back stretches
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;

   lifo_stack_with_peek dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: every accepted beat is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         mirror.check_reply(rsp_bus.data, rsp_bus.status, rsp_bus.full_res,
                            rsp_bus.empty_res);
   end

   // response back-pressure: a random stall before each beat
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // now and then switch between stalling and streaming
         if ($urandom_range(0, 39) == 0)
            receiver_idles = !receiver_idles;
         stall = receiver_idles ? $urandom_range(0, 15) : 0;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // one request beat; valid stays high into the next beat when there is no gap
   task send_request(input cmd_type cmd, input logic signed [VAL_W-1:0] value,
                     input logic [POS_W-1:0] pos);
      int gap;
      gap = sender_idles ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.value    <= value;
      req_bus.position <= pos;
      do @(posedge clock); while (!req_bus.ready);
      mirror.note_request(cmd, value, pos);
   endtask

   // drop valid, let every expected beat arrive and the read pipe drain
   task wait_idle();
      req_bus.valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_capacity(input logic [CAP_W-1:0] cap);
      csr_bus.valid    <= 1'b1;
      csr_bus.capacity <= cap;
      do @(posedge clock); while (!csr_bus.ready);
      mirror.set_capacity(cap);
      csr_bus.valid <= 1'b0;
   endtask

   // random beat: push share given, the rest mostly pops and peeks
   task random_request(input int push_pct);
      cmd_type                 cmd;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        pos;
      int                      pick;
      pick = $urandom_range(0, 99);
      if (pick < push_pct)
         cmd = CMD_PUSH;
      else begin
         pick = $urandom_range(0, 99);
         cmd  = (pick < 55) ? CMD_POP : (pick < 95) ? CMD_PEEK : CMD_NOP;
      end
      // extreme words now and then
      case ($urandom_range(0, 11))
         0:       value = 32'sh7fff_ffff;
         1:       value = 32'sh8000_0000;
         2:       value = '0;
         3:       value = '1;
         default: value = $urandom;
      endcase
      // positions: mostly inside the held range, sometimes anywhere
      if ($urandom_range(0, 3) == 0 || mirror.held == 0)
         pos = POS_W'($urandom_range(0, 127));
      else
         pos = POS_W'($urandom_range(1, mirror.held));
      send_request(cmd, value, pos);
   endtask

   initial begin
      int                  push_pct;
      logic [CAP_W-1:0]    cap;

      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.command  <= CMD_NOP;
      req_bus.value    <= '0;
      req_bus.position <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.capacity <= CAP_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset capacity, empty stack, word extremes, every position case
      send_request(CMD_POP, 32'sd5, 7'd0);
      send_request(CMD_PEEK, 32'sd0, 7'd0);      // empty beats bad position
      send_request(CMD_PEEK, 32'sd0, 7'd5);
      send_request(CMD_NOP, '1, 7'd127);
      send_request(CMD_PUSH, 32'sh7fff_ffff, 7'd0);
      send_request(CMD_PUSH, 32'sh8000_0000, 7'd0);
      send_request(CMD_PUSH, 32'sd0, 7'd0);
      send_request(CMD_PUSH, '1, 7'd127);
      send_request(CMD_PEEK, 32'sd0, 7'd0);
      send_request(CMD_PEEK, 32'sd0, 7'd1);
      send_request(CMD_PEEK, 32'sd0, 7'd4);
      send_request(CMD_PEEK, 32'sd0, 7'd5);
      send_request(CMD_PEEK, 32'sd0, 7'd127);
      send_request(CMD_POP, 32'sd0, 7'd0);
      send_request(CMD_NOP, 32'sd0, 7'd0);
      repeat (4) send_request(CMD_POP, 32'sd0, 7'd0);   // last one underflows

      // capacity zero: always full, pushes refused, both flags up
      wait_idle();
      write_capacity(7'd0);
      send_request(CMD_PUSH, 32'sd11, 7'd0);
      send_request(CMD_PEEK, 32'sd0, 7'd1);

      // small capacity: fill up and overflow
      wait_idle();
      write_capacity(7'd2);
      send_request(CMD_PUSH, 32'sh1234_5678, 7'd0);
      send_request(CMD_PUSH, -32'sd77, 7'd0);
      send_request(CMD_PUSH, 32'sd99, 7'd0);

      // capacity lowered below the count: still full, pops and peeks work
      wait_idle();
      write_capacity(7'd1);
      send_request(CMD_PUSH, 32'sd3, 7'd0);
      send_request(CMD_PEEK, 32'sd0, 7'd2);
      send_request(CMD_POP, 32'sd0, 7'd0);
      send_request(CMD_POP, 32'sd0, 7'd0);

      // random phases; the stack carries over so capacity changes hit a held count
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0, 7:    cap = 7'd127;
            1, 2, 6: cap = 7'd64;
            4:       cap = 7'd0;
            5:       cap = 7'd1;
            8:       cap = CAP_W'($urandom_range(65, 126));
            default: cap = CAP_W'($urandom_range(2, 63));
         endcase
         case (phase)
            0, 1, 6, 7: push_pct = 90;
            2, 8:       push_pct = 25;
            default:    push_pct = 55;
         endcase
         wait_idle();
         write_capacity(cap);
         sender_idles = ($urandom_range(0, 3) != 0);
         repeat (50) random_request(push_pct);
      end

      wait_idle();
      if (mirror.pending() != 0)
         mirror.report($sformatf("%0d expected beats never came", mirror.pending()));
      if (mirror.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #3_000_000;
      $display("timeout at %0t", $time);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
